// File: sv/pes_pkg.sv
// Package for the periodic event scheduler: slot layout, opcodes, status codes.
// No dependencies; pes_if, the core, pes_alu and the testbench import it.
`default_nettype none

package pes_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DUE_W        = 48;
  localparam int ID_W         = 16;
  localparam int PER_W        = 16;

  typedef logic [1:0]       opcode_t;
  typedef logic [1:0]       status_t;
  typedef logic [ID_W-1:0]  id_t;
  typedef logic [PER_W-1:0] period_t;
  typedef logic [DUE_W-1:0] due_t;

  localparam opcode_t OP_REGISTER = 2'd0;
  localparam opcode_t OP_FIRE     = 2'd1;
  localparam opcode_t OP_CLEAR    = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_SAT   = 2'd3;

  localparam due_t DUE_MAX = {DUE_W{1'b1}};

  // Field order makes the packed value the heap key: due time, then id, then period.
  typedef struct packed {
    due_t    due;
    id_t     id;
    period_t period;
  } slot_t;

endpackage

`default_nettype wire

// File: sv/pes_if.sv
// Valid/ready channel interfaces for the scheduler's command and result items.
// Depends on pes_pkg for the field types.
`default_nettype none

interface pes_in_if import pes_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  id_t     source_id;
  period_t period;

  modport source (output valid, output opcode, output source_id, output period, input ready);
  modport sink   (input valid, input opcode, input source_id, input period, output ready);
endinterface

interface pes_out_if import pes_pkg::*; ();
  logic    valid;
  logic    ready;
  id_t     fired_id;
  status_t status;

  modport source (output valid, output fired_id, output status, input ready);
  modport sink   (input valid, input fired_id, input status, output ready);
endinterface

`default_nettype wire

// File: sv/periodic_event_scheduler_core.sv
// Periodic event scheduler: min-heap of periodic sources in a dual-read RAM,
// walked by one sequencer around a shared compare/add unit.
// Depends on pes_pkg, pes_if, pes_ram and pes_alu.
//
// Usage:
//  - in_ch carries command items (opcode, source_id, period); out_ch returns
//    exactly one result item (fired_id, status) per command, in order.
//  - Register inserts a source with first due time equal to its period and
//    sifts it up.
//  - Fire reads the root, advances its due time (saturating), and sifts it
//    down.
//  - Clear, an unused opcode, fire on an empty heap and register on a full
//    heap go straight to the response step.
//  - The sequencer and its single RAM write port set the rate: one command
//    at a time, in_ch.ready is high only while the sequencer is idle.
//  - The result sits in an output register; the next command is taken while
//    it waits. A stalled receiver holds the finished result inside the core
//    until the output register frees up.
//  - Reset (rst_n low, synchronous) empties the heap and drops any pending
//    result. The RAM needs no clearing: only slots below the count are used.
`default_nettype none

module periodic_event_scheduler_core import pes_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pes_in_if.sink    in_ch,
  pes_out_if.source out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_UP_RD    = 9'b000000010,
    S_UP_CMP   = 9'b000000100,
    S_ROOT_RD  = 9'b000001000,
    S_ROOT_ADD = 9'b000010000,
    S_DN_RD    = 9'b000100000,
    S_DN_SEL   = 9'b001000000,
    S_DN_CMP   = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  slot_t           ent_r, ent_nxt;
  slot_t           child_r, child_nxt;
  logic [AW-1:0]   child_pos_r, child_pos_nxt;
  logic            has_right_r, has_right_nxt;
  id_t             res_id_r, res_id_nxt;
  status_t         res_st_r, res_st_nxt;
  logic            out_valid_r, out_valid_nxt;
  id_t             out_id_r, out_id_nxt;
  status_t         out_st_r, out_st_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  slot_t           ram_wdata;
  logic [AW-1:0]   ram_raddr_a, ram_raddr_b;
  logic [$bits(slot_t)-1:0] ram_rdata_a, ram_rdata_b;
  slot_t           rd_a, rd_b;

  slot_t           alu_a, alu_b, alu_adv;
  logic            alu_less, alu_sat;

  logic            in_fire;
  logic [AW-1:0]   pos_m1, parent;
  logic [IW-1:0]   left_w, right_w, count_ext;
  logic            has_left;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.fired_id = out_id_r;
  assign out_ch.status   = out_st_r;

  assign rd_a = slot_t'(ram_rdata_a);
  assign rd_b = slot_t'(ram_rdata_b);

  // Heap index arithmetic around the current hole position.
  assign pos_m1    = pos_r - 1'b1;
  assign parent    = pos_m1 >> 1;
  assign left_w    = {1'b0, pos_r, 1'b1};
  assign right_w   = left_w + 1'b1;
  assign count_ext = IW'(count_r);
  assign has_left  = left_w < count_ext;

  pes_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // Steer the shared unit's operands by sequencer step.
  always_comb begin
    alu_a = ent_r;
    alu_b = rd_a;
    unique case (state_r)
      S_UP_CMP:   begin alu_a = ent_r;   alu_b = rd_a;  end
      S_ROOT_ADD: begin alu_a = rd_a;    alu_b = rd_a;  end
      S_DN_SEL:   begin alu_a = rd_b;    alu_b = rd_a;  end
      S_DN_CMP:   begin alu_a = child_r; alu_b = ent_r; end
      default:    begin alu_a = ent_r;   alu_b = rd_a;  end
    endcase
  end

  pes_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .a_less (alu_less),
    .a_adv  (alu_adv),
    .a_sat  (alu_sat)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    ent_nxt       = ent_r;
    child_nxt     = child_r;
    child_pos_nxt = child_pos_r;
    has_right_nxt = has_right_r;
    res_id_nxt    = res_id_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = ent_r;
    ram_raddr_a   = '0;
    ram_raddr_b   = '0;

    // Drain the output register when the receiver takes the item.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_id_nxt = '0;
          res_st_nxt = ST_OK;
          state_nxt  = S_RESP;
          unique case (in_ch.opcode)
            OP_REGISTER: begin
              if (count_r == CW'(CAPACITY)) begin
                res_st_nxt = ST_FULL;
              end else begin
                ent_nxt.due    = DUE_W'(in_ch.period);
                ent_nxt.id     = in_ch.source_id;
                ent_nxt.period = in_ch.period;
                pos_nxt        = count_r[AW-1:0];
                count_nxt      = count_r + 1'b1;
                state_nxt      = S_UP_RD;
              end
            end
            OP_FIRE: begin
              if (count_r == '0) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_ROOT_RD;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              // unused opcode: report ok, change nothing
            end
          endcase
        end
      end

      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_raddr_a = parent;
          state_nxt   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_we = 1'b1;
        if (alu_less) begin
          // Move the parent down into the hole and climb.
          ram_wdata = rd_a;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_ROOT_RD: begin
        ram_raddr_a = '0;
        state_nxt   = S_ROOT_ADD;
      end

      S_ROOT_ADD: begin
        res_id_nxt = rd_a.id;
        res_st_nxt = alu_sat ? ST_SAT : ST_OK;
        ent_nxt    = alu_adv;
        pos_nxt    = '0;
        state_nxt  = S_DN_RD;
      end

      S_DN_RD: begin
        if (!has_left) begin
          ram_we    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_raddr_a   = left_w[AW-1:0];
          ram_raddr_b   = right_w[AW-1:0];
          has_right_nxt = right_w < count_ext;
          state_nxt     = S_DN_SEL;
        end
      end

      S_DN_SEL: begin
        // Pick the smaller child; right wins only when strictly smaller.
        if (has_right_r && alu_less) begin
          child_nxt     = rd_b;
          child_pos_nxt = right_w[AW-1:0];
        end else begin
          child_nxt     = rd_a;
          child_pos_nxt = left_w[AW-1:0];
        end
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        ram_we = 1'b1;
        if (alu_less) begin
          // Move the child up into the hole and descend.
          ram_wdata = child_r;
          pos_nxt   = child_pos_r;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    ent_r       <= ent_nxt;
    child_r     <= child_nxt;
    child_pos_r <= child_pos_nxt;
    has_right_r <= has_right_nxt;
    res_id_r    <= res_id_nxt;
    res_st_r    <= res_st_nxt;
    out_id_r    <= out_id_nxt;
    out_st_r    <= out_st_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.opcode == OP_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the heap");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.opcode == OP_REGISTER && count_r != CW'(CAPACITY))
      |=> (count_r == $past(count_r) + 1'b1))
    else $error("register did not add one entry");

  a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CW'(ram_waddr) < count_r))
    else $error("heap write outside live entries");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside the response step");

endmodule

`default_nettype wire

// File: sv/pes_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pes_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: sv/pes_alu.sv
// Shared key comparator and saturating due-time advance for the heap sequencer.
// Depends on pes_pkg.
`default_nettype none

module pes_alu import pes_pkg::*; (
  input  wire slot_t a,
  input  wire slot_t b,
  output logic       a_less,
  output slot_t      a_adv,
  output logic       a_sat
);

  logic [DUE_W:0] sum;

  // Packed slot compares as due, id, period in that priority.
  assign a_less = a < b;

  assign sum   = {1'b0, a.due} + (DUE_W + 1)'(a.period);
  assign a_sat = sum[DUE_W];

  always_comb begin
    a_adv     = a;
    a_adv.due = a_sat ? DUE_MAX : sum[DUE_W-1:0];
  end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for periodic_event_scheduler_core: random and directed
// command items, results checked in order against a behavioral heap mirror.
// Depends on pes_pkg, pes_if and the core itself.
`default_nettype none

module testbench;
  import pes_pkg::*;

  localparam int      CAPACITY   = CAPACITY_DEF;
  localparam opcode_t OP_UNUSED  = 2'd3;   // no operation behind this code
  localparam int      RAND_ITEMS = 500;
  localparam int      HOLD_AT    = 150;    // commands taken before the long receiver hold
  localparam int      HOLD_LEN   = 300;    // cycles the receiver keeps ready low
  localparam int      CALM_LO    = 300;    // window with no idling on either side
  localparam int      CALM_HI    = 380;
  localparam int      IDLE_LIMIT = 2000;   // cycles with no item moving before giving up
  localparam int      DRAIN_WAIT = 40;

  typedef struct packed {
    id_t     fired_id;
    status_t status;
  } outcome_t;

  // Mirror of the scheduler: the heap is kept as an unordered set of slots and
  // the fire pick is the smallest key, so the heap layout never matters.
  class sched_mirror;
    slot_t    live[$];
    outcome_t owed[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // Note an accepted command and queue the result it must produce.
    function void take_command(opcode_t op, id_t id, period_t per);
      outcome_t res;
      int       pick;
      res = '{fired_id: '0, status: ST_OK};
      case (op)
        OP_REGISTER: begin
          if (live.size() >= CAPACITY) res.status = ST_FULL;
          else live.push_back(slot_t'{due_t'(per), id, per});
        end
        OP_FIRE: begin
          if (live.size() == 0) begin
            res.status = ST_EMPTY;
          end else begin
            pick = 0;
            for (int i = 1; i < live.size(); i++)
              if (live[i] < live[pick]) pick = i;
            res.fired_id = live[pick].id;
            if (live[pick].due > DUE_MAX - due_t'(live[pick].period)) begin
              live[pick].due = DUE_MAX;
              res.status     = ST_SAT;
            end else begin
              live[pick].due = live[pick].due + due_t'(live[pick].period);
            end
          end
        end
        OP_CLEAR: live.delete();
        default: ;
      endcase
      owed.push_back(res);
    endfunction

    // Compare one result item with the oldest outstanding expectation.
    function void match_result(id_t got_id, status_t got_st);
      outcome_t exp_res;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result fired_id=%0d status=%0d", $time, got_id, got_st);
        errors++;
        return;
      end
      exp_res = owed.pop_front();
      if (got_id !== exp_res.fired_id) begin
        $display("%0t: fired_id mismatch expected=%0d actual=%0d",
                 $time, exp_res.fired_id, got_id);
        errors++;
      end
      if (got_st !== exp_res.status) begin
        $display("%0t: status mismatch expected=%0d actual=%0d",
                 $time, exp_res.status, got_st);
        errors++;
      end
    endfunction

    function int owed_count();
      return owed.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pes_in_if  cmd_ch ();
  pes_out_if res_ch ();

  periodic_event_scheduler_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  sched_mirror book = new();
  int          cmds_taken   = 0;
  int          results_seen = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Ids cluster in a small range so that duplicate ids are common.
  function automatic id_t pick_id();
    if ($urandom_range(99) < 50) return id_t'($urandom_range(15));
    return id_t'($urandom);
  endfunction

  // Short periods make ties and reordering frequent; keep zero rare since a
  // zero-period source pins the head of the heap until the next clear.
  function automatic period_t pick_period();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return period_t'($urandom_range(4, 1));
    if (roll < 43) return '0;
    if (roll < 53) return '1;
    return period_t'($urandom);
  endfunction

  // Offer one command and hold it until the core takes it.
  task automatic send_cmd(opcode_t op, id_t id, period_t per);
    bit calm;
    calm = (cmds_taken >= CALM_LO) && (cmds_taken < CALM_HI);
    while (!calm && $urandom_range(99) < 15) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.opcode    <= op;
    cmd_ch.source_id <= id;
    cmd_ch.period    <= per;
    do @(posedge clk); while (!cmd_ch.ready);
    book.take_command(op, id, per);
    cmds_taken++;
  endtask

  task automatic register_burst(int n);
    for (int i = 0; i < n; i++) send_cmd(OP_REGISTER, pick_id(), pick_period());
  endtask

  // Result side: check every accepted item, idle at random, and hold off once
  // for a long stretch so the core backs up and stalls its command input.
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        book.match_result(res_ch.fired_id, res_ch.status);
        results_seen++;
      end
      if (!hold_done && cmds_taken >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  // Give up when no item moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int kind;
    int n;
    rst_n            <= 1'b0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.opcode    <= OP_CLEAR;
    cmd_ch.source_id <= '0;
    cmd_ch.period    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty heap, the unused code, field extremes, zero period,
    // duplicate ids and the id/period tie-breaks.
    send_cmd(OP_FIRE, '0, '0);
    send_cmd(OP_UNUSED, '1, '1);
    send_cmd(OP_CLEAR, '1, '1);
    send_cmd(OP_REGISTER, '1, '1);
    send_cmd(OP_REGISTER, 16'd0, 16'd1);
    send_cmd(OP_REGISTER, 16'd7, '0);
    send_cmd(OP_REGISTER, 16'd7, '0);
    send_cmd(OP_FIRE, '1, '1);
    send_cmd(OP_FIRE, '0, '0);
    send_cmd(OP_CLEAR, '0, '0);
    send_cmd(OP_REGISTER, 16'd5, 16'd2);
    send_cmd(OP_REGISTER, 16'd5, 16'd1);
    send_cmd(OP_REGISTER, 16'd4, 16'd2);
    send_cmd(OP_REGISTER, 16'd0, 16'd1);
    send_cmd(OP_REGISTER, 16'hAAAA, 16'h5555);
    repeat (6) send_cmd(OP_FIRE, 16'h5555, 16'hAAAA);
    send_cmd(OP_CLEAR, '0, '0);
    send_cmd(OP_FIRE, '0, '0);

    // Fill past capacity so the full case shows up early.
    register_burst(CAPACITY + 2);
    repeat (20) send_cmd(OP_FIRE, pick_id(), pick_period());

    // Random phases: mostly register and fire bursts, some noise and clears.
    while (cmds_taken < RAND_ITEMS + 20) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2: register_burst($urandom_range(24, 1));
        3:       register_burst($urandom_range(70, 40));
        4, 5, 6, 7: begin
          n = $urandom_range(32, 1);
          repeat (n) send_cmd(OP_FIRE, id_t'($urandom), period_t'($urandom));
        end
        8: begin
          n = $urandom_range(10, 1);
          repeat (n)
            send_cmd(opcode_t'($urandom_range(3)), id_t'($urandom), period_t'($urandom));
        end
        default: send_cmd(OP_CLEAR, id_t'($urandom), period_t'($urandom));
      endcase
    end
    cmd_ch.valid <= 1'b0;

    // Drain outstanding results, then let the core settle.
    while (book.owed_count() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (book.errors == 0 && book.owed_count() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
